// ----- design/hcbp_pkg.sv -----
package hcbp_pkg;

  // Default sizes of the code table.
  localparam int MaxCodeLenDefault  = 32;
  localparam int SymbolCountDefault = 256;

  // Fixed widths of the word fields.
  localparam int SymW      = 8;
  localparam int CodeW     = 32;
  localparam int LenW      = 6;
  localparam int QueueBits = 8;
  localparam int HeldW     = 4;
  localparam int OpW       = 2;

  // Operation codes carried on the input tuser.
  localparam logic [OpW-1:0] OP_LOAD   = 2'd0;
  localparam logic [OpW-1:0] OP_ENCODE = 2'd1;
  localparam logic [OpW-1:0] OP_FLUSH  = 2'd2;

  // Command from the sequencer to the bit packer.
  typedef struct packed {
    logic shift_en;
    logic bit_in;
    logic flush;
  } pk_cmd_t;

endpackage

// ----- design/huffman_code_bit_packer.sv -----
// Channel  Direction  tdata                                        tuser / tlast
// s_*      in         symbol[7:0] load_code[39:8] load_length[45:40] tuser: op[1:0]
// m_*      out        out_byte[7:0]                                tlast: last
//
// A load writes the table while the block stays idle. An encode is accepted,
// then reads the table, then shifts the code bits into the packer one at a
// time and closes the shift loop once the count is zero. A flush sends the
// padded last byte. s_tready is high only between items. A stalled
// m_tready holds the shift loop when a full byte must leave. Reset clears the
// length valid bits, the packer and the output valid flag at once, so no
// clearing pass is needed.
module huffman_code_bit_packer
  import hcbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = MaxCodeLenDefault,
  parameter int SYMBOL_COUNT = SymbolCountDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // symbol[7:0], load_code[39:8], load_length[45:40]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic        m_tlast
);

  localparam int AddrW    = $clog2(SYMBOL_COUNT);
  localparam int LenLimit = (MAX_CODE_LEN < CodeW) ? MAX_CODE_LEN : CodeW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [LenW-1:0]      cnt;
  logic [LenW-1:0]      cnt_next;
  logic [LenW-1:0]      pos;
  logic                 in_take;
  logic                 sym_ok;
  logic [SymW-1:0]      sym;
  logic [CodeW-1:0]     lcode;
  logic [LenW-1:0]      llen;
  logic [LenW-1:0]      llen_sat;
  logic [OpW-1:0]       op;
  logic [CodeW-1:0]     rd_code;
  logic [LenW-1:0]      rd_len;
  logic                 out_free;
  logic                 out_load;
  logic                 out_last;
  logic                 pk_full;
  logic [QueueBits-1:0] pk_byte;
  pk_cmd_t              cmd;

  // Input word fields.
  assign op    = s_tuser;
  assign sym   = s_tdata[SymW-1:0];
  assign lcode = s_tdata[SymW+CodeW-1:SymW];
  assign llen  = s_tdata[SymW+CodeW+LenW-1:SymW+CodeW];

  assign s_tready = (state == S_IDLE);
  assign in_take  = s_tvalid && s_tready;
  assign sym_ok   = ({1'b0, sym} < (SymW+1)'(SYMBOL_COUNT));
  assign llen_sat = (llen > LenW'(LenLimit)) ? LenW'(LenLimit) : llen;
  assign out_free = !m_tvalid || m_tready;
  assign pos      = cnt - LenW'(1);

  hcbp_table #(
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .we     (in_take && (op == OP_LOAD) && sym_ok),
    .waddr  (sym[AddrW-1:0]),
    .wcode  (lcode),
    .wlen   (llen_sat),
    .re     (in_take && (op == OP_ENCODE) && sym_ok),
    .raddr  (sym[AddrW-1:0]),
    .rd_code(rd_code),
    .rd_len (rd_len)
  );

  hcbp_packer u_packer (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .full     (pk_full),
    .emit_byte(pk_byte)
  );

  // Sequencer: one code bit per cycle through the packer, unless a full byte waits on a busy output.
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd.shift_en = 1'b0;
    cmd.bit_in   = 1'b0;
    cmd.flush    = 1'b0;
    out_load     = 1'b0;
    out_last     = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          if ((op == OP_ENCODE) && sym_ok) begin
            state_next = S_READ;
          end else if (op == OP_FLUSH) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_READ: begin
        cnt_next   = rd_len;
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        if (cnt == '0) begin
          state_next = S_IDLE;
        end else if (!pk_full || out_free) begin
          cmd.shift_en = 1'b1;
          cmd.bit_in   = rd_code[pos[$clog2(CodeW)-1:0]];
          cnt_next     = pos;
          // The byte is the last one unless eight or more bits follow this one.
          out_load     = pk_full;
          out_last     = (pos < LenW'(QueueBits));
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          cmd.flush  = 1'b1;
          out_load   = 1'b1;
          out_last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= pk_byte;
      m_tlast <= out_last;
    end
  end

  a_shift_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) && (cnt == '0) |=> (state == S_IDLE))
    else $error("shift loop did not end at zero count");

  a_load_single: assert property (@(posedge clk) disable iff (rst)
    in_take && (op == OP_LOAD) |=> (state == S_IDLE) && !cmd.shift_en)
    else $error("load item started work");

  a_cnt_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (cnt <= LenW'(LenLimit)))
    else $error("bit count beyond length limit");

endmodule

// ----- design/hcbp_table.sv -----
module hcbp_table
  import hcbp_pkg::*;
#(
  parameter int SYMBOL_COUNT = SymbolCountDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            we,
  input  logic [$clog2(SYMBOL_COUNT)-1:0] waddr,
  input  logic [CodeW-1:0]                wcode,
  input  logic [LenW-1:0]                 wlen,
  input  logic                            re,
  input  logic [$clog2(SYMBOL_COUNT)-1:0] raddr,
  output logic [CodeW-1:0]                rd_code,
  output logic [LenW-1:0]                 rd_len
);

  logic [CodeW-1:0]        code_mem [SYMBOL_COUNT];
  logic [LenW-1:0]         len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] vld;
  logic [LenW-1:0]         len_q;
  logic                    vld_q;

  // Code word and length storage, read data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      code_mem[waddr] <= wcode;
      len_mem[waddr]  <= wlen;
    end
    if (re) begin
      rd_code <= code_mem[raddr];
      len_q   <= len_mem[raddr];
    end
  end

  // One valid bit per entry so that unwritten lengths read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (we) vld[waddr] <= 1'b1;
      if (re) vld_q <= vld[raddr];
    end
  end

  assign rd_len = vld_q ? len_q : '0;

endmodule

// ----- design/hcbp_packer.sv -----
module hcbp_packer
  import hcbp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  pk_cmd_t              cmd,
  output logic                 full,
  output logic [QueueBits-1:0] emit_byte
);

  logic [QueueBits-1:0] queue;
  logic [HeldW-1:0]     held;

  assign full = (held == HeldW'(QueueBits));

  // A full queue goes out as is; a partial one is padded with zeros below.
  always_comb begin
    if (held == '0) begin
      emit_byte = '0;
    end else if (full) begin
      emit_byte = queue;
    end else begin
      emit_byte = queue << (HeldW'(QueueBits) - held);
    end
  end

  // Shift one code bit in per command; a full queue restarts with the new bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      queue <= '0;
      held  <= '0;
    end else if (cmd.flush) begin
      queue <= '0;
      held  <= '0;
    end else if (cmd.shift_en) begin
      if (full) begin
        queue <= {{(QueueBits-1){1'b0}}, cmd.bit_in};
        held  <= HeldW'(1);
      end else begin
        queue <= {queue[QueueBits-2:0], cmd.bit_in};
        held  <= held + HeldW'(1);
      end
    end
  end

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    held <= HeldW'(QueueBits))
    else $error("bit count beyond queue size");

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> (held == '0) && (queue == '0))
    else $error("queue not empty after flush");

endmodule

// ----- tb/testbench.sv -----
module testbench
  import hcbp_pkg::*;
();

  // The one op code that the package leaves unnamed; the block ignores it.
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

  localparam int LenLimit      = (MaxCodeLenDefault < CodeW) ? MaxCodeLenDefault : CodeW;
  localparam int WatchdogLimit = 3000;
  localparam int DrainCycles   = 80;
  localparam int PhaseItems    = 46;

  typedef struct {
    logic [OpW-1:0]  op;
    logic [SymW-1:0] symbol;
    logic [CodeW-1:0] code;
    logic [LenW-1:0] length;
    int              phase;
  } enc_req_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // symbol[7:0], load_code[39:8], load_length[45:40]
  logic [1:0]  s_tuser = '0;   // op[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // out_byte[7:0]
  logic        m_tlast;

  // Idle percentages per phase: sender busy receiver slow, then the reverse, then none.
  int send_idle_pct [3] = '{21, 74, 0};
  int recv_idle_pct [3] = '{74, 21, 0};

  enc_req_t     pending_words [$];
  packed_byte_t expected_bytes [$];
  enc_req_t     cur_req;
  packed_byte_t want_byte;
  int           rx_phase = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;

  // Predictor state: the code table and the bit packer.
  logic [CodeW-1:0] tbl_code [SymbolCountDefault];
  logic [LenW-1:0]  tbl_len  [SymbolCountDefault] = '{default: '0};
  logic [7:0]       pk_bits = '0;
  int               pk_held = 0;

  // Stimulus bookkeeping: only symbols that were loaded are ever encoded.
  bit       sym_loaded [SymbolCountDefault] = '{default: 1'b0};
  logic [7:0] loaded_syms [$];

  huffman_code_bit_packer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Work out the bytes that one accepted request produces and queue them.
  function automatic void pack_request(enc_req_t req);
    packed_byte_t b;
    packed_byte_t burst [$];
    logic [LenW-1:0] len;
    case (req.op)
      OP_LOAD: begin
        len = (req.length > LenLimit) ? LenW'(LenLimit) : req.length;
        tbl_code[req.symbol] = req.code;
        tbl_len[req.symbol]  = len;
      end
      OP_ENCODE: begin
        for (int pos = int'(tbl_len[req.symbol]) - 1; pos >= 0; pos--) begin
          // A full queue leaves only when the next bit shows up.
          if (pk_held >= QueueBits) begin
            b.data = pk_bits;
            b.last = 1'b0;
            burst.push_back(b);
            pk_held = 0;
          end
          pk_bits = {pk_bits[6:0], tbl_code[req.symbol][pos]};
          pk_held++;
        end
        if (burst.size() != 0) burst[burst.size()-1].last = 1'b1;
        foreach (burst[i]) expected_bytes.push_back(burst[i]);
      end
      OP_FLUSH: begin
        b.data = (pk_held == 0) ? 8'h00 : 8'(pk_bits << (QueueBits - pk_held));
        b.last = 1'b1;
        expected_bytes.push_back(b);
        pk_bits = '0;
        pk_held = 0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void push_req(logic [OpW-1:0] op, logic [7:0] sym, logic [31:0] code,
                                   logic [5:0] len, int phase);
    enc_req_t r;
    r.op     = op;
    r.symbol = sym;
    r.code   = code;
    r.length = len;
    r.phase  = phase;
    pending_words.push_back(r);
    if (op == OP_LOAD && !sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endfunction

  // Mostly short codes, with some long, empty and over-long lengths.
  function automatic logic [5:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 6'($urandom_range(12, 1));
    if (r < 80) return 6'($urandom_range(32, 13));
    if (r < 90) return 6'd0;
    return 6'($urandom_range(63, 33));
  endfunction

  // Driver: present the next request word when the bus is free.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        pack_request(cur_req);
        rx_phase = cur_req.phase;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() != 0 &&
            $urandom_range(99) >= send_idle_pct[pending_words[0].phase]) begin
          cur_req = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {2'b00, cur_req.length, cur_req.code, cur_req.symbol};
          s_tuser  <= cur_req.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output word against the oldest expected byte.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
        end else begin
          want_byte = expected_bytes.pop_front();
          if (m_tdata !== want_byte.data)
            report_mismatch($sformatf("byte %02h, expected %02h", m_tdata, want_byte.data));
          if (m_tlast !== want_byte.last)
            report_mismatch($sformatf("last %0b, expected %0b", m_tlast, want_byte.last));
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct[rx_phase]);
    end
  end

  // Count cycles in which neither side moves a word.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WatchdogLimit) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    int         counted;
    int         r;
    logic [7:0] sym;

    // Directed part: table extremes, saturation, empty codes, full and empty flushes.
    push_req(OP_FLUSH,  8'h00, 32'h0,          6'd0,  0);
    push_req(OP_LOAD,   8'h00, 32'hFFFF_FFFF,  6'd32, 0);
    push_req(OP_LOAD,   8'hFF, 32'h0000_0000,  6'd63, 0);
    push_req(OP_LOAD,   8'h01, 32'hFFFF_FFFD,  6'd3,  0);
    push_req(OP_LOAD,   8'h02, 32'hA5A5_A5A5,  6'd0,  0);
    push_req(OP_LOAD,   8'h03, 32'h0000_0001,  6'd1,  0);
    push_req(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF,  6'h3F, 0);
    push_req(OP_ENCODE, 8'h00, 32'h0,          6'd0,  0);
    push_req(OP_FLUSH,  8'h00, 32'h0,          6'd0,  0);
    push_req(OP_ENCODE, 8'hFF, 32'h0,          6'd0,  0);
    push_req(OP_ENCODE, 8'h00, 32'h0,          6'd0,  0);
    push_req(OP_ENCODE, 8'h02, 32'h0,          6'd0,  0);
    push_req(OP_ENCODE, 8'h01, 32'h0,          6'd0,  0);
    push_req(OP_ENCODE, 8'h01, 32'h0,          6'd0,  0);
    push_req(OP_ENCODE, 8'h03, 32'h0,          6'd0,  0);
    push_req(OP_FLUSH,  8'h00, 32'h0,          6'd0,  0);
    push_req(OP_FLUSH,  8'h00, 32'h0,          6'd0,  0);
    push_req(OP_LOAD,   8'h80, 32'h5A5A_5AB4,  6'd8,  0);
    push_req(OP_ENCODE, 8'h80, 32'h0,          6'd0,  0);
    push_req(OP_ENCODE, 8'h80, 32'h0,          6'd0,  0);
    push_req(OP_ENCODE, 8'h03, 32'h0,          6'd0,  0);
    push_req(OP_FLUSH,  8'h00, 32'h0,          6'd0,  0);

    // Random part: table loads, encode runs and flushes, with some ignored words.
    for (int ph = 0; ph < 3; ph++) begin
      counted = 0;
      while (counted < PhaseItems) begin
        r = $urandom_range(99);
        if (r < 15) begin
          sym = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
          push_req(OP_LOAD, sym, $urandom, pick_length(), ph);
          counted++;
        end else if (r < 75) begin
          sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
          push_req(OP_ENCODE, sym, $urandom, 6'($urandom_range(63)), ph);
          counted++;
        end else if (r < 94) begin
          push_req(OP_FLUSH, 8'($urandom_range(255)), $urandom, 6'($urandom_range(63)), ph);
          counted++;
        end else begin
          push_req(OP_UNUSED, 8'($urandom_range(255)), $urandom, 6'($urandom_range(63)), ph);
        end
      end
    end

    // Let everything drain, then give the block time to show any extra word.
    while (pending_words.size() != 0 || s_tvalid) @(negedge clk);
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/hcbp_pkg.sv
design/hcbp_table.sv
design/hcbp_packer.sv
design/huffman_code_bit_packer.sv
tb/testbench.sv
